// File: rtl/rfba_pkg.sv
// Shared types, constants and codes for the ring FIFO block allocator.
package rfba_pkg;

  localparam int unsigned BUF_BYTES      = 4096;
  localparam int unsigned HDR_BYTES      = 16;
  localparam int unsigned HDR_ALIGN      = 8;
  localparam int unsigned HDR_ALIGN_LOG2 = $clog2(HDR_ALIGN);
  localparam int unsigned MAX_ALIGN_LOG2 = 6;
  localparam int unsigned HDR_SLOTS      = BUF_BYTES / HDR_ALIGN;
  localparam int unsigned SLOT_AW        = $clog2(HDR_SLOTS);
  localparam int unsigned MIN_LIMIT      = 2 * HDR_BYTES + 1;

  localparam int unsigned PTR_W  = 13;  // header pointers, sizes, offsets
  localparam int unsigned OFF_W  = 12;  // reported block offsets
  localparam int unsigned CALC_W = 15;  // fit arithmetic, no overflow
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;

  localparam logic [PTR_W-1:0] BUF_SIZE_RESET = PTR_W'(4096);

  // Register index (byte address bit 2 and up)
  localparam logic [CFG_AW-3:0] REG_BUF_LEN = '0;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FAIL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    op_e              opcode;
    logic [PTR_W-1:0] blk_bytes;
    logic [2:0]       align_log2;
    logic [PTR_W-1:0] align_offset;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [OFF_W-1:0] block_offset;
    logic             first_valid;
    logic [OFF_W-1:0] first_offset;
    logic             is_empty_flag;
  } rsp_t;

  typedef struct packed {
    logic             wrap;
    logic [PTR_W-1:0] next_off;
    logic [PTR_W-1:0] user_off;
  } hdr_t;

  localparam int unsigned HDR_W = $bits(hdr_t);

  // Controller -> datapath commands
  typedef struct packed {
    logic latch;       // capture the incoming transaction
    logic clear_ptrs;  // oldest = next free = 0
    logic calc_user;   // register aligned user offset
    logic commit;      // write header, advance next free
    logic wrap_mark;   // write wrap mark, restart from 0
    logic rd_en;       // header RAM read
    logic rd_zero;     // read slot 0 instead of oldest
    logic base_zero;   // use 0 instead of oldest as base
    logic adv_oldest;  // oldest = base + next_off
    logic first_set;   // first = base + user_off
    logic first_none;  // no oldest live block
    logic set_fail;
    logic set_empty;
    logic load_out;    // move result into output register
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic empty;       // oldest == next free
    logic next_zero;   // next free == 0
    logic start_zero;  // oldest == 0
    logic cross_fail;  // block would cross the oldest header
    logic fits;        // next header fits before the end
    logic rd_wrap;     // wrap mark of the header just read
  } sts_t;

endpackage

// File: rtl/rfba_ram.sv
// Generic single write port, single read port RAM with registered read.
module rfba_ram #(
  parameter int unsigned DATA_W = 27,
  parameter int unsigned DEPTH  = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/rfba_dpath.sv
// Allocator datapath: pointers, fit arithmetic, header RAM, config register.
module rfba_dpath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rfba_pkg::cmd_t               cmd_i,
  output rfba_pkg::sts_t               sts_o,
  input  rfba_pkg::req_t               in_data_i,
  output rfba_pkg::rsp_t               out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rfba_pkg::CFG_AW-1:0]  paddr,
  input  logic [rfba_pkg::CFG_DW-1:0]  pwdata,
  output logic [rfba_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready
);

  localparam int unsigned PW = rfba_pkg::PTR_W;
  localparam int unsigned CW = rfba_pkg::CALC_W;
  localparam int unsigned OW = rfba_pkg::OFF_W;
  localparam int unsigned AW = rfba_pkg::SLOT_AW;
  localparam int unsigned SL = rfba_pkg::HDR_ALIGN_LOG2;
  localparam int unsigned CFG_AW_HI = rfba_pkg::CFG_AW - 1;

  // control state
  logic [PW-1:0] buf_size_q, oldest_q, next_q;
  logic [PW-1:0] buf_size_d, oldest_d, next_d;

  // transaction payload
  logic [PW-1:0]     end_q, size_q, aoff_q;
  logic [2:0]        alog_q;
  logic [CW-1:0]     user_q;
  rfba_pkg::status_e status_q;
  logic [OW-1:0]     blk_q, fo_q;
  logic              fv_q;
  rfba_pkg::rsp_t    out_q;

  logic          cfg_wr, reg_hit;
  logic [PW-1:0] limit;
  logic [2:0]    alog_sat;
  logic [CW-1:0] amask, end_x, aoff_x, size_x, start_x, limit_x;
  logic [CW-1:0] base_sum, rounded, user_d, nend, next_off_w, user_off_w;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr, ram_raddr;
  rfba_pkg::hdr_t               wr_hdr, rd_hdr;
  logic [rfba_pkg::HDR_W-1:0]   ram_rdata;
  logic [PW-1:0]                base, adv_sum, first_sum;

  // config port
  assign reg_hit = (paddr[CFG_AW_HI:2] == rfba_pkg::REG_BUF_LEN);
  assign cfg_wr  = psel && penable && pwrite && reg_hit;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? rfba_pkg::CFG_DW'(buf_size_q) : '0;

  // buffer end, clamped
  always_comb begin
    if (buf_size_q > PW'(rfba_pkg::BUF_BYTES)) begin
      limit = PW'(rfba_pkg::BUF_BYTES);
    end else if (buf_size_q < PW'(rfba_pkg::MIN_LIMIT)) begin
      limit = PW'(rfba_pkg::MIN_LIMIT);
    end else begin
      limit = buf_size_q;
    end
  end

  // fit arithmetic: step 1 aligns the user block, step 2 checks the fit
  assign alog_sat = (alog_q > 3'(rfba_pkg::MAX_ALIGN_LOG2)) ?
                    3'(rfba_pkg::MAX_ALIGN_LOG2) : alog_q;
  assign amask    = ~({CW{1'b1}} << alog_sat);
  assign end_x    = CW'(end_q);
  assign aoff_x   = CW'(aoff_q);
  assign size_x   = CW'(size_q);
  assign start_x  = CW'(oldest_q);
  assign limit_x  = CW'(limit);

  assign base_sum = end_x + CW'(rfba_pkg::HDR_BYTES) + aoff_x;
  assign rounded  = (base_sum + amask) & ~amask;
  assign user_d   = rounded - aoff_x;

  assign nend = (user_q + size_x + CW'(rfba_pkg::HDR_ALIGN - 1))
                & ~CW'(rfba_pkg::HDR_ALIGN - 1);
  assign next_off_w = nend - end_x;
  assign user_off_w = user_q - end_x;

  assign sts_o.cross_fail = (nend >= start_x) != (end_x >= start_x);
  assign sts_o.fits       = (nend + CW'(rfba_pkg::HDR_BYTES)) <= limit_x;
  assign sts_o.empty      = (oldest_q == next_q);
  assign sts_o.next_zero  = (next_q == '0);
  assign sts_o.start_zero = (oldest_q == '0);
  assign sts_o.rd_wrap    = rd_hdr.wrap;

  // header RAM
  always_comb begin
    wr_hdr = '0;
    if (cmd_i.commit) begin
      wr_hdr.next_off = next_off_w[PW-1:0];
      wr_hdr.user_off = user_off_w[PW-1:0];
    end else begin
      wr_hdr.wrap = 1'b1;
    end
  end

  assign ram_we    = cmd_i.commit || cmd_i.wrap_mark;
  assign ram_waddr = end_q[SL +: AW];
  assign ram_raddr = cmd_i.rd_zero ? '0 : oldest_q[SL +: AW];

  rfba_ram #(
    .DATA_W (rfba_pkg::HDR_W),
    .DEPTH  (rfba_pkg::HDR_SLOTS)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_hdr),
    .re_i    (cmd_i.rd_en),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_hdr    = ram_rdata;
  assign base      = cmd_i.base_zero ? '0 : oldest_q;
  assign adv_sum   = base + rd_hdr.next_off;
  assign first_sum = base + rd_hdr.user_off;

  // pointer update
  always_comb begin
    buf_size_d = buf_size_q;
    oldest_d   = oldest_q;
    next_d     = next_q;
    if (cfg_wr) begin
      buf_size_d = pwdata[PW-1:0];
      oldest_d   = '0;
      next_d     = '0;
    end else if (cmd_i.clear_ptrs) begin
      oldest_d = '0;
      next_d   = '0;
    end else begin
      if (cmd_i.commit) begin
        next_d = nend[PW-1:0];
      end
      if (cmd_i.adv_oldest) begin
        oldest_d = adv_sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_size_q <= rfba_pkg::BUF_SIZE_RESET;
      oldest_q   <= '0;
      next_q     <= '0;
    end else begin
      buf_size_q <= buf_size_d;
      oldest_q   <= oldest_d;
      next_q     <= next_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      end_q    <= next_q;
      size_q   <= in_data_i.blk_bytes;
      alog_q   <= in_data_i.align_log2;
      aoff_q   <= in_data_i.align_offset;
      status_q <= rfba_pkg::ST_DONE;
      blk_q    <= '0;
    end
    if (cmd_i.wrap_mark) begin
      end_q <= '0;
    end
    if (cmd_i.calc_user) begin
      user_q <= user_d;
    end
    if (cmd_i.commit) begin
      blk_q <= user_q[OW-1:0];
    end
    if (cmd_i.set_fail) begin
      status_q <= rfba_pkg::ST_FAIL;
    end
    if (cmd_i.set_empty) begin
      status_q <= rfba_pkg::ST_EMPTY;
    end
    if (cmd_i.first_set) begin
      fv_q <= 1'b1;
      fo_q <= first_sum[OW-1:0];
    end
    if (cmd_i.first_none) begin
      fv_q <= 1'b0;
      fo_q <= '0;
    end
    if (cmd_i.load_out) begin
      out_q.status        <= status_q;
      out_q.block_offset  <= blk_q;
      out_q.first_valid   <= fv_q;
      out_q.first_offset  <= fo_q;
      out_q.is_empty_flag <= (oldest_q == next_q);
    end
  end

  assign out_data_o = out_q;

endmodule

// File: rtl/rfba_ctrl.sv
// Allocator sequencer: walks each transaction through fit, free and report steps.
module rfba_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  rfba_pkg::op_e  in_opcode_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rfba_pkg::cmd_t cmd_o,
  input  rfba_pkg::sts_t sts_i
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_ALLOC_U  = 9'b000000010,
    S_ALLOC_F  = 9'b000000100,
    S_FREE_CHK = 9'b000001000,
    S_FREE_ADV = 9'b000010000,
    S_REP_RD   = 9'b000100000,
    S_REP_CHK  = 9'b001000000,
    S_REP_WRAP = 9'b010000000,
    S_OUT      = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   retry_q, retry_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    retry_d = retry_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          case (in_opcode_i)
            rfba_pkg::OP_ALLOC: begin
              retry_d = 1'b0;
              state_d = S_ALLOC_U;
            end
            rfba_pkg::OP_FREE: begin
              cmd_o.rd_en = 1'b1;
              state_d     = S_FREE_CHK;
            end
            rfba_pkg::OP_CLEAR: begin
              cmd_o.clear_ptrs = 1'b1;
              state_d          = S_REP_RD;
            end
            default: state_d = S_REP_RD;
          endcase
        end
      end
      S_ALLOC_U: begin
        cmd_o.calc_user = 1'b1;
        state_d         = S_ALLOC_F;
      end
      S_ALLOC_F: begin
        state_d = S_REP_RD;
        if (sts_i.cross_fail) begin
          cmd_o.set_fail = 1'b1;
        end else if (sts_i.fits) begin
          cmd_o.commit = 1'b1;
        end else if (retry_q || sts_i.start_zero) begin
          cmd_o.set_fail = 1'b1;
        end else begin
          cmd_o.wrap_mark = 1'b1;
          retry_d         = 1'b1;
          state_d         = S_ALLOC_U;
        end
      end
      S_FREE_CHK: begin
        if (sts_i.empty) begin
          cmd_o.set_empty  = 1'b1;
          cmd_o.first_none = 1'b1;
          state_d          = S_OUT;
        end else if (sts_i.rd_wrap) begin
          if (sts_i.next_zero) begin
            cmd_o.set_empty  = 1'b1;
            cmd_o.first_none = 1'b1;
            state_d          = S_OUT;
          end else begin
            cmd_o.rd_en   = 1'b1;
            cmd_o.rd_zero = 1'b1;
            state_d       = S_FREE_ADV;
          end
        end else begin
          cmd_o.adv_oldest = 1'b1;
          state_d          = S_REP_RD;
        end
      end
      S_FREE_ADV: begin
        cmd_o.adv_oldest = 1'b1;
        cmd_o.base_zero  = 1'b1;
        state_d          = S_REP_RD;
      end
      S_REP_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_REP_CHK;
      end
      S_REP_CHK: begin
        if (sts_i.empty) begin
          cmd_o.first_none = 1'b1;
          state_d          = S_OUT;
        end else if (sts_i.rd_wrap) begin
          if (sts_i.next_zero) begin
            cmd_o.first_none = 1'b1;
            state_d          = S_OUT;
          end else begin
            cmd_o.rd_en   = 1'b1;
            cmd_o.rd_zero = 1'b1;
            state_d       = S_REP_WRAP;
          end
        end else begin
          cmd_o.first_set = 1'b1;
          state_d         = S_OUT;
        end
      end
      S_REP_WRAP: begin
        cmd_o.first_set = 1'b1;
        cmd_o.base_zero = 1'b1;
        state_d         = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.load_out || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      retry_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      retry_q     <= retry_d;
      out_valid_q <= out_valid_d;
    end
  end

  // one transaction in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("transaction accepted while another is in flight");

  // a wrap mark is written at most once per allocation, then the retry runs
  a_single_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wrap_mark |=> (state_q == S_ALLOC_U) && retry_q)
    else $error("wrap mark without a following retry");

  // a new result only appears after the report step
  a_out_from_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result raised outside the report step");

  // a finished result waits while the previous one is stalled
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_valid_q && out_stall_i) |=> state_q == S_OUT)
    else $error("pending result overwritten");

endmodule

// File: rtl/ring_fifo_block_allocator_top.sv
// Ring FIFO block allocator: top level joining sequencer and datapath.
// Transactions are taken one at a time, only in the idle state; the header RAM has a single
// read port with registered read, and a stalled result holds the next transaction in S_OUT.
// Reset: both pointers zero, size register 4096; the header RAM is not cleared.
module ring_fifo_block_allocator_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  rfba_pkg::req_t              in_data_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output rfba_pkg::rsp_t              out_data_o,
  // config port, single size register at byte address 0
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rfba_pkg::CFG_AW-1:0] paddr,
  input  logic [rfba_pkg::CFG_DW-1:0] pwdata,
  output logic [rfba_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);

  // Sequencer drives one command word per cycle; the datapath answers
  // with compare results and the wrap bit of the last header read.
  rfba_pkg::cmd_t cmd;
  rfba_pkg::sts_t sts;

  // Each transaction is accepted only in the idle state. The result sits in
  // an output register, so the next transaction can be accepted while the
  // previous result is still stalled downstream.
  rfba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_opcode_i (in_data_i.opcode),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Datapath holds oldest/next-free header pointers, the header RAM
  // (one entry per 8-byte slot: wrap mark, next offset, user offset),
  // the two-step fit arithmetic and the size register. A config
  // write also empties the buffer.
  rfba_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

endmodule

// File: test/tb_ring_fifo_block_allocator_top.sv
// Self-checking testbench for the ring FIFO block allocator top level.
module tb_ring_fifo_block_allocator_top;

  // Cycles with no transaction, no result and no register access before giving up.
  // The slowest item stalls far less than this: a drawn request gap, a drawn result
  // stall and the steps inside the block.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_GAP        = 19;
  localparam int unsigned SETTLE_CYCLES  = 12;  // block latency plus margin
  localparam int unsigned RANDOM_ITEMS   = 1325;

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             in_valid_i;
  logic                             in_stall_o;
  rfba_pkg::req_t                   in_data_i;
  logic                             out_valid_o;
  logic                             out_stall_i;
  rfba_pkg::rsp_t                   out_data_o;
  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [rfba_pkg::CFG_AW-1:0]      paddr;
  logic [rfba_pkg::CFG_DW-1:0]      pwdata;
  logic [rfba_pkg::CFG_DW-1:0]      prdata;
  logic                             pready;

  ring_fifo_block_allocator_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Allocator shadow state: size register, both header pointers and one header
  // record per 8-byte slot. Kept in step with every accepted transaction.
  // ---------------------------------------------------------------------------
  logic [rfba_pkg::PTR_W-1:0] size_reg;
  int unsigned                oldest_hdr;
  int unsigned                free_hdr;
  logic [rfba_pkg::PTR_W-1:0] slot_next [rfba_pkg::HDR_SLOTS];
  logic                       slot_wrap [rfba_pkg::HDR_SLOTS];
  logic [rfba_pkg::PTR_W-1:0] slot_user [rfba_pkg::HDR_SLOTS];

  rfba_pkg::rsp_t expected_rsp [$];
  int unsigned    errors;
  int unsigned    results_seen;
  int unsigned    idle_cycles;
  bit             req_taken;
  bit             rsp_taken;
  bit             apb_done;
  bit             quiet;  // no idling on either side while set

  function automatic int unsigned slot_idx(input int unsigned off);
    return (off / rfba_pkg::HDR_ALIGN) % rfba_pkg::HDR_SLOTS;
  endfunction

  function automatic int unsigned round_up(input int unsigned x, input int unsigned a);
    return (x + a - 1) & ~(a - 1);
  endfunction

  // Effective end of the buffer: the register clamped to what the block supports.
  function automatic int unsigned buffer_end();
    int unsigned e;
    e = size_reg;
    if (e > rfba_pkg::BUF_BYTES) e = rfba_pkg::BUF_BYTES;
    if (e < rfba_pkg::MIN_LIMIT) e = rfba_pkg::MIN_LIMIT;
    return e;
  endfunction

  // Header of the oldest live block, stepping over a wrap mark.
  function automatic bit find_live_head(output int unsigned hdr);
    hdr = oldest_hdr;
    if (oldest_hdr == free_hdr) return 1'b0;
    if (slot_wrap[slot_idx(oldest_hdr)]) begin
      hdr = 0;
      if (free_hdr == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Places one block; the wrap mark of a failed retry is left behind on purpose.
  function automatic bit place_block(input int unsigned size, input int unsigned alog,
                                     input int unsigned aoff, output int unsigned user);
    int unsigned align;
    int unsigned base;
    int unsigned lim;
    int unsigned nend;
    int unsigned s;
    bit          wrapped;
    wrapped = 1'b0;
    if (alog > rfba_pkg::MAX_ALIGN_LOG2) alog = rfba_pkg::MAX_ALIGN_LOG2;
    align = 1 << alog;
    base  = free_hdr;
    lim   = buffer_end();
    forever begin
      user = round_up(base + rfba_pkg::HDR_BYTES + aoff, align) - aoff;
      nend = round_up(user + size, rfba_pkg::HDR_ALIGN);
      if ((nend >= oldest_hdr) != (base >= oldest_hdr)) return 1'b0;
      if (nend + rfba_pkg::HDR_BYTES <= lim) begin
        s            = slot_idx(base);
        slot_next[s] = rfba_pkg::PTR_W'(nend - base);
        slot_user[s] = rfba_pkg::PTR_W'(user - base);
        slot_wrap[s] = 1'b0;
        free_hdr     = nend;
        return 1'b1;
      end
      if (wrapped || oldest_hdr == 0) return 1'b0;
      slot_wrap[slot_idx(base)] = 1'b1;
      base    = 0;
      wrapped = 1'b1;
    end
  endfunction

  function automatic rfba_pkg::rsp_t predict_allocation(input rfba_pkg::req_t r);
    rfba_pkg::rsp_t o;
    int unsigned    user;
    int unsigned    h;
    bit             live;
    o        = '0;
    o.status = rfba_pkg::ST_DONE;
    case (r.opcode)
      rfba_pkg::OP_ALLOC: begin
        if (place_block(r.blk_bytes, r.align_log2, r.align_offset, user))
          o.block_offset = rfba_pkg::OFF_W'(user);
        else
          o.status = rfba_pkg::ST_FAIL;
      end
      rfba_pkg::OP_FREE: begin
        if (find_live_head(h))
          oldest_hdr = h + slot_next[slot_idx(h)];
        else
          o.status = rfba_pkg::ST_EMPTY;
      end
      rfba_pkg::OP_CLEAR: begin
        oldest_hdr = 0;
        free_hdr   = 0;
      end
      default: ;
    endcase
    live          = find_live_head(h);
    o.first_valid = live;
    if (live) o.first_offset = rfba_pkg::OFF_W'(h + slot_user[slot_idx(h)]);
    o.is_empty_flag = (oldest_hdr == free_hdr);
    return o;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    errors++;
    $display("mismatch on result %0d: %s got %0d want %0d", results_seen, field, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Edge monitor: checks results, checks register reads, tracks register writes
  // and predicts each accepted transaction. All values here are pre-edge values.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    rfba_pkg::rsp_t want;
    req_taken <= rst_ni && in_valid_i && !in_stall_o;
    rsp_taken <= rst_ni && out_valid_o && !out_stall_i;
    apb_done  <= rst_ni && psel && penable && pready;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_rsp.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = expected_rsp[0];
          expected_rsp.delete(0);
          if (out_data_o.status != want.status)
            report_mismatch("status", out_data_o.status, want.status);
          if (out_data_o.block_offset != want.block_offset)
            report_mismatch("block_offset", out_data_o.block_offset, want.block_offset);
          if (out_data_o.first_valid != want.first_valid)
            report_mismatch("first_valid", out_data_o.first_valid, want.first_valid);
          if (out_data_o.first_offset != want.first_offset)
            report_mismatch("first_offset", out_data_o.first_offset, want.first_offset);
          if (out_data_o.is_empty_flag != want.is_empty_flag)
            report_mismatch("is_empty_flag", out_data_o.is_empty_flag, want.is_empty_flag);
        end
        results_seen++;
      end
      if (psel && penable && pready &&
          paddr[rfba_pkg::CFG_AW-1:2] == rfba_pkg::REG_BUF_LEN) begin
        if (pwrite) begin
          // a size write also empties the buffer
          size_reg   = pwdata[rfba_pkg::PTR_W-1:0];
          oldest_hdr = 0;
          free_hdr   = 0;
        end else if (prdata != rfba_pkg::CFG_DW'(size_reg)) begin
          report_mismatch("size register read", prdata, size_reg);
        end
      end
      if (in_valid_i && !in_stall_o)
        expected_rsp.insert(expected_rsp.size(), predict_allocation(in_data_i));
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Gap drawn per transaction on either side; at least half of the draws give no gap.
  function automatic int unsigned draw_gap();
    if (quiet || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  // Result side: stall for a drawn number of cycles before each result.
  initial begin
    int unsigned hold;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      hold = draw_gap();
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(negedge clk_i); while (!rsp_taken);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. Every task starts and ends just after a falling edge.
  // ---------------------------------------------------------------------------
  task automatic send_item(input rfba_pkg::req_t r);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(negedge clk_i); while (!req_taken);
  endtask

  task automatic send_request(input rfba_pkg::op_e op, input int unsigned size,
                              input int unsigned alog, input int unsigned aoff);
    rfba_pkg::req_t r;
    r.opcode       = op;
    r.blk_bytes    = rfba_pkg::PTR_W'(size);
    r.align_log2   = 3'(alog);
    r.align_offset = rfba_pkg::PTR_W'(aoff);
    send_item(r);
  endtask

  // Every result in, then let the block settle before touching the register.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_rsp.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic apb_access(input bit wr, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {rfba_pkg::REG_BUF_LEN, 2'b00};
    pwdata  <= rfba_pkg::CFG_DW'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!apb_done);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write then read back; the monitor checks the read data.
  task automatic set_buffer_size(input int unsigned value);
    wait_idle();
    apb_access(1'b1, value);
    apb_access(1'b0, 0);
  endtask

  function automatic rfba_pkg::req_t random_request(input int unsigned span);
    rfba_pkg::req_t r;
    int unsigned    pick;
    pick = $urandom_range(0, 99);
    if (pick < 52)      r.opcode = rfba_pkg::OP_ALLOC;
    else if (pick < 92) r.opcode = rfba_pkg::OP_FREE;
    else if (pick < 96) r.opcode = rfba_pkg::OP_CLEAR;
    else                r.opcode = rfba_pkg::OP_NOP;
    // field values are random for every opcode, so ignored fields see noise too
    pick = $urandom_range(0, 9);
    if (pick == 0)      r.blk_bytes = rfba_pkg::PTR_W'($urandom_range(0, 8191));
    else if (pick == 1) r.blk_bytes = rfba_pkg::PTR_W'($urandom_range(0, 15));
    else                r.blk_bytes = rfba_pkg::PTR_W'($urandom_range(0, span / 3));
    r.align_log2 = 3'($urandom_range(0, 7));
    pick = $urandom_range(0, 9);
    if (pick == 0)      r.align_offset = rfba_pkg::PTR_W'($urandom_range(0, 8191));
    else if (pick < 3)  r.align_offset = rfba_pkg::PTR_W'($urandom_range(0, span));
    else                r.align_offset = rfba_pkg::PTR_W'($urandom_range(0, 63));
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_values();
    apb_access(1'b0, 0);                                 // reset size reads back as 4096
    send_request(rfba_pkg::OP_FREE, 0, 0, 0);            // nothing to free
    send_request(rfba_pkg::OP_NOP, 8191, 7, 8191);       // unused opcode, all fields high
    send_request(rfba_pkg::OP_CLEAR, 0, 0, 0);
  endtask

  task automatic test_directed_ops();
    send_request(rfba_pkg::OP_ALLOC, 0, 0, 0);      // zero size block behind first header
    send_request(rfba_pkg::OP_ALLOC, 8191, 0, 0);   // too big, oldest at 0: no wrap
    send_request(rfba_pkg::OP_ALLOC, 100, 7, 8191); // alignment above max saturates
    send_request(rfba_pkg::OP_ALLOC, 1000, 6, 5);
    send_request(rfba_pkg::OP_FREE, 0, 0, 0);
    send_request(rfba_pkg::OP_FREE, 0, 0, 0);
    send_request(rfba_pkg::OP_ALLOC, 3000, 3, 0);   // wraps, retry crosses oldest, mark stays
    send_request(rfba_pkg::OP_FREE, 0, 0, 0);       // frees the last live block
    send_request(rfba_pkg::OP_ALLOC, 2500, 0, 0);   // overwrites the stale wrap mark
    send_request(rfba_pkg::OP_ALLOC, 1000, 0, 0);   // wraps to 0 and fits
    send_request(rfba_pkg::OP_FREE, 0, 0, 0);       // oldest is now a wrap mark
    send_request(rfba_pkg::OP_FREE, 0, 0, 0);       // steps over the mark
    send_request(rfba_pkg::OP_ALLOC, 2900, 0, 0);
    send_request(rfba_pkg::OP_ALLOC, 1000, 0, 0);   // retry ends exactly on oldest: fail
    send_request(rfba_pkg::OP_CLEAR, 0, 0, 0);
    send_request(rfba_pkg::OP_FREE, 0, 0, 0);
  endtask

  task automatic test_size_register();
    set_buffer_size(rfba_pkg::MIN_LIMIT);           // smallest usable buffer
    send_request(rfba_pkg::OP_ALLOC, 0, 0, 0);
    send_request(rfba_pkg::OP_ALLOC, 0, 0, 0);      // no room, oldest at 0
    send_request(rfba_pkg::OP_FREE, 0, 0, 0);
    send_request(rfba_pkg::OP_ALLOC, 0, 0, 0);      // wrap attempt runs into oldest
    set_buffer_size(8191);                          // clamps to the full buffer
    send_request(rfba_pkg::OP_ALLOC, 4064, 0, 0);   // ends exactly at the buffer end
    set_buffer_size(0);                             // clamps up to the minimum
    send_request(rfba_pkg::OP_ALLOC, 1, 0, 0);
  endtask

  task automatic test_random_traffic();
    int unsigned sizes [11] = '{4096, 33, 100, 257, 600, 1024, 2000, 8191, 0, 0, 0};
    int unsigned span;
    int unsigned per_phase;
    sizes[9]  = $urandom_range(33, 4096);
    sizes[10] = $urandom_range(0, 8191);
    per_phase = RANDOM_ITEMS / 11;
    for (int p = 0; p < 11; p++) begin
      set_buffer_size(sizes[p]);
      span  = buffer_end();
      quiet = (p % 4 == 3);                    // some phases run back to back
      for (int i = 0; i < per_phase; i++) send_item(random_request(span));
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    quiet       = 1'b0;
    errors      = 0;
    results_seen = 0;
    size_reg    = rfba_pkg::BUF_SIZE_RESET;
    oldest_hdr  = 0;
    free_hdr    = 0;
    for (int s = 0; s < rfba_pkg::HDR_SLOTS; s++) begin
      slot_next[s] = '0;
      slot_wrap[s] = 1'b0;
      slot_user[s] = '0;
    end
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_values();
    test_directed_ops();
    test_size_register();
    test_random_traffic();

    wait_idle();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/rfba_pkg.sv
rtl/rfba_ram.sv
rtl/rfba_dpath.sv
rtl/rfba_ctrl.sv
rtl/ring_fifo_block_allocator_top.sv
test/tb_ring_fifo_block_allocator_top.sv
